FILE: hdl/csst_pkg.sv
`default_nettype none
package csst_pkg;

  localparam int unsigned MaxAgents = 32;
  localparam int unsigned AddrW     = $clog2(MaxAgents);
  localparam int unsigned CntW      = AddrW + 1;
  localparam int unsigned MaxRadius = 255;
  localparam int unsigned RecBytes  = 29;
  localparam logic [63:0] FnvOffset = 64'hCBF29CE484222325;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_RETARGET = 3'd2,
    CMD_STEP     = 3'd3,
    CMD_HASH     = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_OK,
    EM_AGENT,
    EM_SUM,
    EM_HASH,
    EM_ZERO
  } emit_e;

  typedef enum logic [1:0] {
    WR_RDATA,
    WR_NEW,
    WR_RETGT,
    WR_COPY
  } wsel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SC_RD,
    ST_SC_EV,
    ST_SH_RD,
    ST_SH_EV,
    ST_RM_RD,
    ST_RM_EV,
    ST_RI,
    ST_LI,
    ST_PAIR,
    ST_CLAMP,
    ST_AGENT,
    ST_CP_RD,
    ST_CP_WR,
    ST_HS_CNT,
    ST_HS_RD,
    ST_HS_BYTE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        en;
    logic [7:0]  rad;
    logic [30:0] lim;
    logic [31:0] gy;
    logic [31:0] gx;
    logic [31:0] py;
    logic [31:0] px;
    logic [31:0] id;
  } rec_t;

  typedef struct packed {
    logic             latch_in;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    wsel_e            wr_sel;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             self_ld;
    logic             pair_en;
    logic             pair_self;
    logic             clamp_go;
    logic             nb_wr;
    logic             sum_clr;
    logic             hash_init;
    logic             hash_byte;
    logic             hash_cnt;
    logic [4:0]       byte_sel;
    emit_e            emit;
    logic             ok;
  } ctl_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            id_hit;
    logic            id_gt;
    logic            add_good;
    logic            bounds_ok;
    logic            self_act;
    logic            out_free;
  } sts_t;

  typedef struct packed {
    logic [63:0]     hash;
    logic [5:0]      st;
    logic [5:0]      mt;
    logic [5:0]      at;
    logic            sp;
    logic            mv;
    logic [31:0]     ny;
    logic [31:0]     nx;
    logic [31:0]     id;
    logic            ok;
  } out_t;

endpackage
`default_nettype wire

FILE: hdl/csst_ctrl.sv
`default_nettype none
module csst_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [2:0]    in_cmd_i,
  output logic               in_ready_o,
  input  csst_pkg::sts_t     sts_i,
  output csst_pkg::ctl_t     ctl_o
);

  csst_pkg::state_e state_q, state_d;
  csst_pkg::cmd_e   cmd_q, cmd_d;
  csst_pkg::emit_e  em_q, em_d;
  logic [csst_pkg::CntW-1:0] k_q, k_d, j_q, j_d;
  logic [4:0] b_q, b_d;
  logic       ok_q, ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csst_pkg::ST_IDLE;
      cmd_q   <= csst_pkg::CMD_ADD;
      em_q    <= csst_pkg::EM_NONE;
      k_q     <= '0;
      j_q     <= '0;
      b_q     <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      em_q    <= em_d;
      k_q     <= k_d;
      j_q     <= j_d;
      b_q     <= b_d;
      ok_q    <= ok_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    em_d    = em_q;
    k_d     = k_q;
    j_d     = j_q;
    b_d     = b_q;
    ok_d    = ok_q;
    ctl_o   = '0;
    ctl_o.wr_sel = csst_pkg::WR_RDATA;
    ctl_o.emit   = csst_pkg::EM_NONE;
    in_ready_o = (state_q == csst_pkg::ST_IDLE);

    unique case (state_q)
      csst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch_in = 1'b1;
          cmd_d = csst_pkg::cmd_e'(in_cmd_i);
          k_d   = '0;
          j_d   = '0;
          b_d   = '0;
          unique case (in_cmd_i)
            csst_pkg::CMD_ADD, csst_pkg::CMD_REMOVE, csst_pkg::CMD_RETARGET:
              state_d = csst_pkg::ST_SC_RD;
            csst_pkg::CMD_STEP: begin
              ctl_o.sum_clr = 1'b1;
              em_d = csst_pkg::EM_SUM;
              state_d = sts_i.bounds_ok ? csst_pkg::ST_RI : csst_pkg::ST_EMIT;
            end
            csst_pkg::CMD_HASH: begin
              ctl_o.hash_init = 1'b1;
              state_d = csst_pkg::ST_HS_CNT;
            end
            default: begin
              em_d = csst_pkg::EM_ZERO;
              state_d = csst_pkg::ST_EMIT;
            end
          endcase
        end
      end

      // linear id search: read an entry, then compare its id
      csst_pkg::ST_SC_RD: begin
        if (k_q == sts_i.count) begin
          em_d = csst_pkg::EM_OK;
          ok_d = 1'b0;
          if (cmd_q == csst_pkg::CMD_ADD && sts_i.add_good) begin
            state_d = csst_pkg::ST_SH_RD;
          end else begin
            state_d = csst_pkg::ST_EMIT;
          end
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_addr = k_q[csst_pkg::AddrW-1:0];
          state_d = csst_pkg::ST_SC_EV;
        end
      end

      csst_pkg::ST_SC_EV: begin
        if (sts_i.id_hit) begin
          em_d = csst_pkg::EM_OK;
          unique case (cmd_q)
            csst_pkg::CMD_REMOVE: state_d = csst_pkg::ST_RM_RD;
            csst_pkg::CMD_RETARGET: begin
              ctl_o.wr_en   = 1'b1;
              ctl_o.wr_addr = k_q[csst_pkg::AddrW-1:0];
              ctl_o.wr_sel  = csst_pkg::WR_RETGT;
              ok_d    = 1'b1;
              state_d = csst_pkg::ST_EMIT;
            end
            default: begin
              ok_d    = 1'b0;
              state_d = csst_pkg::ST_EMIT;
            end
          endcase
        end else begin
          k_d = k_q + 1'b1;
          state_d = csst_pkg::ST_SC_RD;
        end
      end

      // sorted insert: move larger ids up one slot from the top
      csst_pkg::ST_SH_RD: begin
        if (k_q == '0) begin
          ctl_o.wr_en   = 1'b1;
          ctl_o.wr_addr = '0;
          ctl_o.wr_sel  = csst_pkg::WR_NEW;
          ctl_o.cnt_inc = 1'b1;
          ok_d    = 1'b1;
          state_d = csst_pkg::ST_EMIT;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_addr = csst_pkg::AddrW'(k_q - 1'b1);
          state_d = csst_pkg::ST_SH_EV;
        end
      end

      csst_pkg::ST_SH_EV: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wr_addr = k_q[csst_pkg::AddrW-1:0];
        if (sts_i.id_gt) begin
          ctl_o.wr_sel = csst_pkg::WR_RDATA;
          k_d     = k_q - 1'b1;
          state_d = csst_pkg::ST_SH_RD;
        end else begin
          ctl_o.wr_sel  = csst_pkg::WR_NEW;
          ctl_o.cnt_inc = 1'b1;
          ok_d    = 1'b1;
          state_d = csst_pkg::ST_EMIT;
        end
      end

      csst_pkg::ST_RM_RD: begin
        if ((k_q + 1'b1) == sts_i.count) begin
          ctl_o.cnt_dec = 1'b1;
          ok_d    = 1'b1;
          state_d = csst_pkg::ST_EMIT;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_addr = csst_pkg::AddrW'(k_q + 1'b1);
          state_d = csst_pkg::ST_RM_EV;
        end
      end

      csst_pkg::ST_RM_EV: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wr_addr = k_q[csst_pkg::AddrW-1:0];
        ctl_o.wr_sel  = csst_pkg::WR_RDATA;
        k_d     = k_q + 1'b1;
        state_d = csst_pkg::ST_RM_RD;
      end

      // step: k walks the agents, j streams the neighbors one per cycle
      csst_pkg::ST_RI: begin
        if (k_q == sts_i.count) begin
          j_d     = '0;
          state_d = csst_pkg::ST_CP_RD;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_addr = k_q[csst_pkg::AddrW-1:0];
          state_d = csst_pkg::ST_LI;
        end
      end

      csst_pkg::ST_LI: begin
        ctl_o.self_ld = 1'b1;
        j_d = '0;
        if (sts_i.self_act) begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_addr = '0;
          state_d = csst_pkg::ST_PAIR;
        end else begin
          state_d = csst_pkg::ST_CLAMP;
        end
      end

      csst_pkg::ST_PAIR: begin
        ctl_o.pair_en   = 1'b1;
        ctl_o.pair_self = (j_q == k_q);
        if ((j_q + 1'b1) == sts_i.count) begin
          state_d = csst_pkg::ST_CLAMP;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_addr = csst_pkg::AddrW'(j_q + 1'b1);
          j_d = j_q + 1'b1;
        end
      end

      csst_pkg::ST_CLAMP: begin
        ctl_o.clamp_go = 1'b1;
        state_d = csst_pkg::ST_AGENT;
      end

      csst_pkg::ST_AGENT: begin
        if (sts_i.out_free) begin
          ctl_o.nb_wr   = 1'b1;
          ctl_o.wr_addr = k_q[csst_pkg::AddrW-1:0];
          ctl_o.emit    = csst_pkg::EM_AGENT;
          k_d     = k_q + 1'b1;
          state_d = csst_pkg::ST_RI;
        end
      end

      csst_pkg::ST_CP_RD: begin
        if (j_q == sts_i.count) begin
          em_d    = csst_pkg::EM_SUM;
          state_d = csst_pkg::ST_EMIT;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_addr = j_q[csst_pkg::AddrW-1:0];
          state_d = csst_pkg::ST_CP_WR;
        end
      end

      csst_pkg::ST_CP_WR: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wr_addr = j_q[csst_pkg::AddrW-1:0];
        ctl_o.wr_sel  = csst_pkg::WR_COPY;
        j_d     = j_q + 1'b1;
        state_d = csst_pkg::ST_CP_RD;
      end

      // hash: one byte per cycle, with a table read between records
      csst_pkg::ST_HS_CNT: begin
        ctl_o.hash_byte = 1'b1;
        ctl_o.hash_cnt  = 1'b1;
        ctl_o.byte_sel  = b_q;
        if (b_q == 5'd3) begin
          k_d     = '0;
          state_d = csst_pkg::ST_HS_RD;
        end else begin
          b_d = b_q + 1'b1;
        end
      end

      csst_pkg::ST_HS_RD: begin
        if (k_q == sts_i.count) begin
          em_d    = csst_pkg::EM_HASH;
          state_d = csst_pkg::ST_EMIT;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_addr = k_q[csst_pkg::AddrW-1:0];
          b_d     = '0;
          state_d = csst_pkg::ST_HS_BYTE;
        end
      end

      csst_pkg::ST_HS_BYTE: begin
        ctl_o.hash_byte = 1'b1;
        ctl_o.byte_sel  = b_q;
        if (b_q == 5'(csst_pkg::RecBytes - 1)) begin
          k_d     = k_q + 1'b1;
          state_d = csst_pkg::ST_HS_RD;
        end else begin
          b_d = b_q + 1'b1;
        end
      end

      csst_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.emit = em_q;
          ctl_o.ok   = ok_q;
          state_d    = csst_pkg::ST_IDLE;
        end
      end

      default: state_d = csst_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/csst_dp.sv
`default_nettype none
module csst_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_addr_i,
  input  wire logic [31:0]   cfg_wdata_i,
  input  wire logic [231:0]  in_data_i,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output csst_pkg::out_t     out_o,
  output logic               out_last_o,
  input  csst_pkg::ctl_t     ctl_i,
  output csst_pkg::sts_t     sts_o
);

  localparam logic [2:0] CfgBx = 3'd0, CfgBy = 3'd1, CfgBw = 3'd2, CfgBh = 3'd3,
                         CfgLimit = 3'd4;

  logic signed [31:0] bx_q, by_q, bw_q, bh_q;
  logic [5:0]         agent_limit_q;
  logic [csst_pkg::CntW-1:0] count_q;

  // latched input item
  logic [31:0] in_id_q, in_px_q, in_py_q, in_gx_q, in_gy_q, in_lim_q, in_rad_q;
  logic        in_act_q;
  logic signed [33:0] hi_x_q, hi_y_q;

  csst_pkg::rec_t rec_mem [csst_pkg::MaxAgents];
  logic [63:0]    nb_mem  [csst_pkg::MaxAgents];
  csst_pkg::rec_t rdata_q;
  logic [63:0]    nb_rdata_q;

  csst_pkg::rec_t  self_q;
  logic            act_q, sep_q;
  logic signed [7:0] dx_q, dy_q, dxc_q, dyc_q;
  logic [5:0]      moved_q, sepd_q;
  logic [63:0]     hash_q;
  csst_pkg::out_t  out_q, out_d;
  logic            out_valid_q, out_last_q, out_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bx_q <= '0;
      by_q <= '0;
      bw_q <= '0;
      bh_q <= '0;
      agent_limit_q <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgBx:    bx_q <= cfg_wdata_i;
        CfgBy:    by_q <= cfg_wdata_i;
        CfgBw:    bw_q <= cfg_wdata_i;
        CfgBh:    bh_q <= cfg_wdata_i;
        CfgLimit: agent_limit_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.cnt_inc) begin
      count_q <= count_q + 1'b1;
    end else if (ctl_i.cnt_dec) begin
      count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      in_id_q  <= in_data_i[31:0];
      in_px_q  <= in_data_i[63:32];
      in_py_q  <= in_data_i[95:64];
      in_gx_q  <= in_data_i[127:96];
      in_gy_q  <= in_data_i[159:128];
      in_lim_q <= in_data_i[191:160];
      in_rad_q <= in_data_i[223:192];
      in_act_q <= in_data_i[224];
      hi_x_q   <= {{2{bx_q[31]}}, bx_q} + {{2{bw_q[31]}}, bw_q} - 34'sd1;
      hi_y_q   <= {{2{by_q[31]}}, by_q} + {{2{bh_q[31]}}, bh_q} - 34'sd1;
    end
  end

  // effective limit for the add checks
  logic [csst_pkg::CntW-1:0] eff_limit;
  always_comb begin
    if (agent_limit_q == '0) begin
      eff_limit = csst_pkg::CntW'(1);
    end else if (agent_limit_q > 6'(csst_pkg::MaxAgents)) begin
      eff_limit = csst_pkg::CntW'(csst_pkg::MaxAgents);
    end else begin
      eff_limit = csst_pkg::CntW'(agent_limit_q);
    end
  end

  // memories
  csst_pkg::rec_t new_rec, wr_rec;
  always_comb begin
    new_rec.id  = in_id_q;
    new_rec.px  = in_px_q;
    new_rec.py  = in_py_q;
    new_rec.gx  = in_gx_q;
    new_rec.gy  = in_gy_q;
    new_rec.lim = in_lim_q[30:0];
    new_rec.rad = in_rad_q[7:0];
    new_rec.en  = in_act_q;
    wr_rec = rdata_q;
    unique case (ctl_i.wr_sel)
      csst_pkg::WR_RDATA: wr_rec = rdata_q;
      csst_pkg::WR_NEW:   wr_rec = new_rec;
      csst_pkg::WR_RETGT: begin
        wr_rec.gx = in_gx_q;
        wr_rec.gy = in_gy_q;
      end
      csst_pkg::WR_COPY: begin
        wr_rec.px = nb_rdata_q[31:0];
        wr_rec.py = nb_rdata_q[63:32];
      end
      default: wr_rec = rdata_q;
    endcase
  end

  logic [31:0] new_x, new_y;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      rec_mem[ctl_i.wr_addr] <= wr_rec;
    end
    if (ctl_i.nb_wr) begin
      nb_mem[ctl_i.wr_addr] <= {new_y, new_x};
    end
    if (ctl_i.rd_en) begin
      rdata_q    <= rec_mem[ctl_i.rd_addr];
      nb_rdata_q <= nb_mem[ctl_i.rd_addr];
    end
  end

  // neighbor test against the agent held in self_q
  logic signed [32:0] ox, oy, ax, ay;
  logic               near;
  logic signed [7:0]  sgx, sgy, gsx, gsy;
  always_comb begin
    ox = {self_q.px[31], self_q.px} - {rdata_q.px[31], rdata_q.px};
    oy = {self_q.py[31], self_q.py} - {rdata_q.py[31], rdata_q.py};
    ax = ox[32] ? -ox : ox;
    ay = oy[32] ? -oy : oy;
    near = (ax <= $signed({25'b0, self_q.rad})) && (ay <= $signed({25'b0, self_q.rad}));
    sgx = ox[32] ? -8'sd1 : (ox != '0 ? 8'sd1 : 8'sd0);
    sgy = oy[32] ? -8'sd1 : (oy != '0 ? 8'sd1 : 8'sd0);
    gsx = ($signed(rdata_q.gx) > $signed(rdata_q.px)) ? 8'sd1 :
          (($signed(rdata_q.gx) < $signed(rdata_q.px)) ? -8'sd1 : 8'sd0);
    gsy = ($signed(rdata_q.gy) > $signed(rdata_q.py)) ? 8'sd1 :
          (($signed(rdata_q.gy) < $signed(rdata_q.py)) ? -8'sd1 : 8'sd0);
  end

  // move clamp against the step limit
  logic signed [31:0] lim_s, dx32, dy32;
  logic signed [7:0]  dxc, dyc;
  always_comb begin
    lim_s = $signed({1'b0, self_q.lim});
    dx32  = 32'(dx_q);
    dy32  = 32'(dy_q);
    if (dx32 > lim_s) dxc = lim_s[7:0];
    else if (dx32 < -lim_s) dxc = 8'(-lim_s);
    else dxc = dx_q;
    if (dy32 > lim_s) dyc = lim_s[7:0];
    else if (dy32 < -lim_s) dyc = 8'(-lim_s);
    else dyc = dy_q;
  end

  // bounds clamp
  logic signed [33:0] nx, ny, lo_x, lo_y, cx, cy;
  logic               mv;
  always_comb begin
    nx   = {{2{self_q.px[31]}}, self_q.px} + 34'(dxc_q);
    ny   = {{2{self_q.py[31]}}, self_q.py} + 34'(dyc_q);
    lo_x = {{2{bx_q[31]}}, bx_q};
    lo_y = {{2{by_q[31]}}, by_q};
    cx   = (nx < lo_x) ? lo_x : ((nx > hi_x_q) ? hi_x_q : nx);
    cy   = (ny < lo_y) ? lo_y : ((ny > hi_y_q) ? hi_y_q : ny);
    new_x = act_q ? cx[31:0] : self_q.px;
    new_y = act_q ? cy[31:0] : self_q.py;
    mv    = (new_x != self_q.px) || (new_y != self_q.py);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.self_ld) begin
      self_q <= rdata_q;
      act_q  <= rdata_q.en && (rdata_q.lim != '0);
      sep_q  <= 1'b0;
      dx_q   <= gsx;
      dy_q   <= gsy;
    end else if (ctl_i.pair_en && !ctl_i.pair_self && rdata_q.en && near) begin
      dx_q  <= dx_q + sgx;
      dy_q  <= dy_q + sgy;
      sep_q <= 1'b1;
    end
    if (ctl_i.clamp_go) begin
      dxc_q <= dxc;
      dyc_q <= dyc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moved_q <= '0;
      sepd_q  <= '0;
    end else if (ctl_i.sum_clr) begin
      moved_q <= '0;
      sepd_q  <= '0;
    end else if (ctl_i.emit == csst_pkg::EM_AGENT) begin
      moved_q <= moved_q + 6'(mv);
      sepd_q  <= sepd_q + 6'(sep_q);
    end
  end

  // fnv-1a, multiply by 2^40 + 435 as shifts and adds
  logic [231:0] rec_v;
  logic [31:0]  cnt_v;
  logic [7:0]   hbyte;
  logic [63:0]  hx, hmul;
  always_comb begin
    rec_v = {7'b0, rdata_q.en, 24'b0, rdata_q.rad, 1'b0, rdata_q.lim,
             rdata_q.gy, rdata_q.gx, rdata_q.py, rdata_q.px, rdata_q.id};
    cnt_v = 32'(count_q);
    hbyte = ctl_i.hash_cnt ? cnt_v[8*ctl_i.byte_sel[1:0] +: 8] : rec_v[8*ctl_i.byte_sel +: 8];
    hx    = hash_q ^ {56'b0, hbyte};
    hmul  = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4) + (hx << 1) + hx;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.hash_init) begin
      hash_q <= csst_pkg::FnvOffset;
    end else if (ctl_i.hash_byte) begin
      hash_q <= hmul;
    end
  end

  // result register
  always_comb begin
    out_d      = '0;
    out_last_d = 1'b1;
    unique case (ctl_i.emit)
      csst_pkg::EM_OK: out_d.ok = ctl_i.ok;
      csst_pkg::EM_AGENT: begin
        out_d.id   = self_q.id;
        out_d.nx   = new_x;
        out_d.ny   = new_y;
        out_d.mv   = mv;
        out_d.sp   = sep_q;
        out_last_d = 1'b0;
      end
      csst_pkg::EM_SUM: begin
        out_d.at = 6'(count_q);
        out_d.mt = moved_q;
        out_d.st = sepd_q;
      end
      csst_pkg::EM_HASH: out_d.hash = hash_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit != csst_pkg::EM_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit != csst_pkg::EM_NONE) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    sts_o.count     = count_q;
    sts_o.id_hit    = (rdata_q.id == in_id_q);
    sts_o.id_gt     = (rdata_q.id > in_id_q);
    sts_o.add_good  = (in_id_q != '0) && (count_q < eff_limit) && !in_lim_q[31] &&
                      !in_rad_q[31] && (in_rad_q <= 32'(csst_pkg::MaxRadius));
    sts_o.bounds_ok = (bw_q > 32'sd0) && (bh_q > 32'sd0);
    sts_o.self_act  = rdata_q.en && (rdata_q.lim != '0);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire

FILE: hdl/crowd_separation_step_table.sv
// one command at a time; s_axis_tready is high only between commands
// add/remove/retarget: a read then a compare or move per table entry searched or shifted
// step: every entry streams past each active agent over a single-port table read, then
//   each agent is clamped and emitted; a read and a write per agent then commit positions
// hash: one byte per cycle through the fnv multiply, with a table read between records
// reset clears agent count and control, resets the configuration; tables need no clearing
`default_nettype none
module crowd_separation_step_table (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // agent_id, position_x, position_y, goal_x, goal_y, step_limit, sep_radius, active
  input  wire logic [231:0] s_axis_tdata,
  // command
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // ok, out_id, new_x, new_y, did_move, did_separate, agent_total, moved_total,
  // separated_total, hash_value
  output logic [183:0]      m_axis_tdata,
  output logic              m_axis_tlast,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [31:0]  cfg_wdata_i
);

  csst_pkg::ctl_t ctl;
  csst_pkg::sts_t sts;
  csst_pkg::out_t res;

  csst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  csst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (res),
    .out_last_o  (m_axis_tlast),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

  assign m_axis_tdata = {3'b0, res};

endmodule
`default_nettype wire
